// ===== hdl/cdat_pkg.sv =====
`default_nettype none

package cdat_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_SUB      = 2'd1;
    localparam logic [1:0] OP_DIST     = 2'd2;
    localparam logic [1:0] OP_VALIDATE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [15:0] DIST_LIM     = 16'd65535;
    localparam logic [14:0] RECIP_25     = 15'd20972;   // ceil(2^19 / 25)
    localparam int          RECIP_SHIFT  = 19;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        logic [1:0]  operation;
        date_t       base;
        date_t       other;
        logic [15:0] day_count;
    } item_t;

    typedef struct packed {
        date_t       date;
        logic [15:0] day_distance;
        logic [1:0]  status;
    } result_t;

    // Gregorian leap rule; y % 25 by reciprocal multiply, exact for 14-bit years
    function automatic logic is_leap(input logic [13:0] y);
        logic [28:0] prod;
        logic [9:0]  q;
        logic [13:0] back;
        logic        div25;
        prod  = {15'd0, y} * {14'd0, RECIP_25};
        q     = prod[RECIP_SHIFT +: 10];
        back  = ({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q};
        div25 = (back == y);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input date_t d, input logic leap);
        return (d.year <= YEAR_MAX) && (d.month >= 4'd1) && (d.month <= 4'd12)
            && (d.day >= 5'd1) && (d.day <= month_len(d.month, leap));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cdat_step.sv =====
`default_nettype none

// Shared one-day step unit: next or previous calendar day.
module cdat_step (
    input  cdat_pkg::date_t cur,
    input  logic            leap,
    input  logic            fwd,
    output cdat_pkg::date_t nxt,
    output logic            at_edge
);
    import cdat_pkg::*;

    logic [4:0] len_cur;
    logic [4:0] len_prev;
    logic [3:0] prev_month;

    assign len_cur    = month_len(cur.month, leap);
    assign prev_month = cur.month - 4'd1;
    assign len_prev   = month_len(prev_month, leap);

    always_comb
    begin
        nxt = cur;
        if (fwd)
        begin
            at_edge = (cur.year == YEAR_MAX) && (cur.month == 4'd12) && (cur.day == 5'd31);
            if (cur.day < len_cur)
            begin
                nxt.day = cur.day + 5'd1;
            end
            else if (cur.month < 4'd12)
            begin
                nxt.month = cur.month + 4'd1;
                nxt.day   = 5'd1;
            end
            else
            begin
                nxt.year  = cur.year + 14'd1;
                nxt.month = 4'd1;
                nxt.day   = 5'd1;
            end
        end
        else
        begin
            at_edge = (cur.year == 14'd0) && (cur.month == 4'd1) && (cur.day == 5'd1);
            if (cur.day > 5'd1)
            begin
                nxt.day = cur.day - 5'd1;
            end
            else if (cur.month > 4'd1)
            begin
                nxt.month = prev_month;
                nxt.day   = len_prev;
            end
            else
            begin
                nxt.year  = cur.year - 14'd1;
                nxt.month = 4'd12;
                nxt.day   = 5'd31;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cdat_seq.sv =====
`default_nettype none

// Sequencer: checks dates, then walks one day per cycle through cdat_step.
module cdat_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdat_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_take,
    output cdat_pkg::result_t res
);
    import cdat_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg;
    date_t       base_reg;
    date_t       cur_reg, cur_next;
    date_t       oth_reg, oth_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [1:0]  st_reg, st_next;
    logic        leap_reg;
    logic        oth_leap_reg;

    date_t       step_date;
    logic        step_edge;
    logic        fwd;
    logic        base_first;

    assign fwd        = (op_reg != OP_SUB);
    assign base_first = ({cur_reg.year, cur_reg.month, cur_reg.day}
                       < {oth_reg.year, oth_reg.month, oth_reg.day});

    cdat_step u_step (
        .cur     (cur_reg),
        .leap    (leap_reg),
        .fwd     (fwd),
        .nxt     (step_date),
        .at_edge (step_edge)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status       = st_reg;
        res.date         = base_reg;
        res.day_distance = 16'd0;
        if (st_reg != ST_INVALID)
        begin
            if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
            begin
                res.date = cur_reg;
            end
            else if (op_reg == OP_DIST)
            begin
                res.day_distance = cnt_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        oth_next   = oth_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next   = item.base;
                    oth_next   = item.other;
                    cnt_next   = item.day_count;
                    st_next    = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!date_ok(cur_reg, leap_reg))
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_VALIDATE)
                begin
                    state_next = S_DONE;
                end
                else if (op_reg == OP_DIST)
                begin
                    if (!date_ok(oth_reg, oth_leap_reg))
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // walk the earlier date up to the later one
                        cnt_next = 16'd0;
                        if (!base_first)
                        begin
                            cur_next = oth_reg;
                            oth_next = cur_reg;
                        end
                        state_next = S_SETTLE;
                    end
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_SETTLE:
            begin
                // leap flag follows the swapped walker
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (op_reg == OP_DIST)
                begin
                    if (cur_reg == oth_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (cnt_reg == DIST_LIM)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = step_date;
                        cnt_next = cnt_reg + 16'd1;
                    end
                end
                else
                begin
                    if (cnt_reg == 16'd0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (step_edge)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = step_date;
                        cnt_next = cnt_reg - 16'd1;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            op_reg   <= item.operation;
            base_reg <= item.base;
        end
        cur_reg      <= cur_next;
        oth_reg      <= oth_next;
        cnt_reg      <= cnt_next;
        st_reg       <= st_next;
        leap_reg     <= is_leap(cur_next.year);
        oth_leap_reg <= is_leap(oth_next.year);
    end

`ifndef SYNTH
    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && res_take |=> (state_reg == S_IDLE))
        else $error("done state not left after result transfer");

    a_walker_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cur_reg.month >= 4'd1) && (cur_reg.month <= 4'd12)
            && (cur_reg.day >= 5'd1))
        else $error("walker left the calendar");

    a_walker_year: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cur_reg.year <= YEAR_MAX))
        else $error("walker passed the last year");

    a_dist_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && (op_reg == OP_DIST) |->
            ({cur_reg.year, cur_reg.month, cur_reg.day}
             <= {oth_reg.year, oth_reg.month, oth_reg.day}))
        else $error("distance walker overtook its target");
`endif

endmodule

`default_nettype wire

// ===== hdl/calendar_date_arithmetic_core.sv =====
`default_nettype none

// Channel  Dir  tdata fields (lsb first)                          tuser
// s_*      in   base d/m/y, other d/m/y, day_count (5,4,14,...)    operation
// m_*      out  result d/m/y, day_distance (5,4,14,16), pad 1       status
//
// Flow: dates are checked, then the one-day step unit walks day_count days
// for add/subtract, or from the earlier date to the later (capped at 65535
// days) for a distance; validate and invalid dates skip the walk.
// Reset: rst_n asynchronous, clears control; the block comes up idle.
// The result sits in an output register, so a new item is taken while
// m_tvalid waits on m_tready; s_tready is low while an item is in work.
module calendar_date_arithmetic_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] base_day, [8:5] base_month, [22:9] base_year, [27:23] other_day,
    // [31:28] other_month, [45:32] other_year, [61:46] day_count, [63:62] zero
    input  logic [63:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] result_day, [8:5] result_month, [22:9] result_year,
    // [38:23] day_distance, [39] zero
    output logic [39:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);
    import cdat_pkg::*;

    item_t   item;
    result_t res;
    logic    res_valid;
    logic    res_take;
    logic    out_valid_reg;
    result_t out_reg;

    // unpack the input transfer
    assign item.operation    = s_tuser;
    assign item.base.day     = s_tdata[4:0];
    assign item.base.month   = s_tdata[8:5];
    assign item.base.year    = s_tdata[22:9];
    assign item.other.day    = s_tdata[27:23];
    assign item.other.month  = s_tdata[31:28];
    assign item.other.year   = s_tdata[45:32];
    assign item.day_count    = s_tdata[61:46];

    cdat_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register: loads when empty or being drained this cycle
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.day_distance, out_reg.date.year,
                       out_reg.date.month, out_reg.date.day};
    assign m_tuser  = out_reg.status;

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_INVALID) || (m_tuser == ST_RANGE))
        else $error("undefined status code");

    a_dist_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_INVALID) |-> (m_tdata[38:23] == 16'd0))
        else $error("distance reported with an invalid date");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

// Self-checking bench for calendar_date_arithmetic_core.
// Each transfer on the s_ side is turned into an expected result by a local
// Gregorian calendar model and queued. The m_ side checker pops the queue in
// order and compares every field. Both sides insert random gaps and stalls.
module tb;
    import cdat_pkg::*;

    // serial day number of 9999-12-31, with day 0 = 0000-01-01
    localparam int LAST_DAY = 365 * 10000 + 10003 / 4 - 10099 / 100 + 10399 / 400 - 1;

    typedef struct {
        date_t       date;
        logic [15:0] distance;
        logic [1:0]  status;
    } date_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // base d/m/y, other d/m/y, day_count, two zero pad bits (lsb first)
    logic [63:0] s_tdata;
    // operation
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // result d/m/y, day_distance, one zero pad bit (lsb first)
    logic [39:0] m_tdata;
    // status
    logic [1:0]  m_tuser;

    date_result_t pending_results[$];
    int           errors;
    bit           no_gaps;     // forces back-to-back traffic on both sides
    int           stall_left;

    calendar_date_arithmetic_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    //------------------------------------------------------------------
    // Calendar model
    //------------------------------------------------------------------
    function automatic bit leap_of(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_of(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit valid_date(input date_t d);
        return (d.year <= YEAR_MAX) && (d.month >= 1) && (d.month <= 12) && (d.day >= 1)
            && (int'(d.day) <= days_in_month(int'(d.month), int'(d.year)));
    endfunction

    // days elapsed since 0000-01-01; only called on valid dates
    function automatic int day_number(input date_t d);
        int y;
        int s;
        y = int'(d.year);
        s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int k = 1; k < int'(d.month); k++)
            s += days_in_month(k, y);
        return s + int'(d.day) - 1;
    endfunction

    function automatic date_t date_of(input int s);
        date_t d;
        int    y;
        int    rem;
        int    m;
        int    len;
        y   = (s / 146097) * 400;   // 400-year cycles have a fixed length
        rem = s % 146097;
        len = leap_of(y) ? 366 : 365;
        while (rem >= len) begin
            rem -= len;
            y++;
            len = leap_of(y) ? 366 : 365;
        end
        m   = 1;
        len = days_in_month(m, y);
        while (rem >= len) begin
            rem -= len;
            m++;
            len = days_in_month(m, y);
        end
        d.day   = 5'(rem + 1);
        d.month = 4'(m);
        d.year  = 14'(y);
        return d;
    endfunction

    function automatic date_t ymd(input int y, input int m, input int d);
        date_t r;
        r.year  = 14'(y);
        r.month = 4'(m);
        r.day   = 5'(d);
        return r;
    endfunction

    // date n days away, clamped to the calendar span
    function automatic date_t shift_date(input date_t d, input int n);
        int s;
        s = day_number(d) + n;
        if (s < 0)
            s = 0;
        if (s > LAST_DAY)
            s = LAST_DAY;
        return date_of(s);
    endfunction

    function automatic date_result_t predict_date_result(input logic [1:0] op,
                                                         input date_t base, input date_t other,
                                                         input logic [15:0] count);
        date_result_t r;
        int           s;
        int           o;
        int           cnt;
        int           diff;
        r.date     = base;
        r.distance = '0;
        r.status   = ST_OK;
        cnt        = int'(count);
        if (!valid_date(base)) begin
            r.status = ST_INVALID;
        end else begin
            case (op)
                OP_ADD: begin
                    s = day_number(base);
                    if (cnt > LAST_DAY - s) begin
                        s        = LAST_DAY;
                        r.status = ST_RANGE;
                    end else begin
                        s += cnt;
                    end
                    r.date = date_of(s);
                end
                OP_SUB: begin
                    s = day_number(base);
                    if (cnt > s) begin
                        s        = 0;
                        r.status = ST_RANGE;
                    end else begin
                        s -= cnt;
                    end
                    r.date = date_of(s);
                end
                OP_DIST: begin
                    if (!valid_date(other)) begin
                        r.status = ST_INVALID;
                    end else begin
                        s    = day_number(base);
                        o    = day_number(other);
                        diff = (s > o) ? s - o : o - s;
                        if (diff > int'(DIST_LIM)) begin
                            diff     = int'(DIST_LIM);
                            r.status = ST_RANGE;
                        end
                        r.distance = 16'(diff);
                    end
                end
                default: ;   // validate: base date echoed, nothing else
            endcase
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Clock, reset, watchdog
    //------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog that fails the run if it never finishes
    initial begin
        #(8 * 8_000_000);
        $display("calendar_date_arithmetic_core test failed");
        $finish;
    end

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    //------------------------------------------------------------------
    // Result side: random backpressure and in-order checking
    //------------------------------------------------------------------
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        date_result_t exp_res;
        date_t        got_date;
        logic [15:0]  got_dist;
        if (rst_n && m_tvalid && m_tready) begin
            got_date = date_t'(m_tdata[22:0]);
            got_dist = m_tdata[38:23];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: %0d-%0d-%0d dist %0d status %0d",
                         $time, got_date.year, got_date.month, got_date.day, got_dist, m_tuser);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_date.day !== exp_res.date.day) begin
                    errors++;
                    $display("%0t: result_day expected %0d actual %0d",
                             $time, exp_res.date.day, got_date.day);
                end
                if (got_date.month !== exp_res.date.month) begin
                    errors++;
                    $display("%0t: result_month expected %0d actual %0d",
                             $time, exp_res.date.month, got_date.month);
                end
                if (got_date.year !== exp_res.date.year) begin
                    errors++;
                    $display("%0t: result_year expected %0d actual %0d",
                             $time, exp_res.date.year, got_date.year);
                end
                if (got_dist !== exp_res.distance) begin
                    errors++;
                    $display("%0t: day_distance expected %0d actual %0d",
                             $time, exp_res.distance, got_dist);
                end
                if (m_tuser !== exp_res.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, m_tuser);
                end
                if (m_tdata[39] !== 1'b0) begin
                    errors++;
                    $display("%0t: pad bit expected 0 actual %b", $time, m_tdata[39]);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------
    // Called right after a posedge; tvalid stays high on return so that
    // back-to-back transfers never lower and raise it in one step.
    task automatic send_request(input logic [1:0] op, input date_t base, input date_t other,
                                input logic [15:0] count);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, count, other, base};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_date_result(op, base, other, count));
    endtask

    task automatic release_bus();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_validation();
        date_t z;
        z = ymd(0, 0, 0);
        send_request(OP_VALIDATE, ymd(0, 1, 1), z, 16'd0);
        send_request(OP_VALIDATE, ymd(9999, 12, 31), z, 16'd0);
        send_request(OP_VALIDATE, ymd(2000, 2, 29), z, 16'd0);   // 400-year leap
        send_request(OP_VALIDATE, ymd(1900, 2, 29), z, 16'd0);   // century, not leap
        send_request(OP_VALIDATE, ymd(0, 2, 29), z, 16'd0);      // year 0 is leap
        send_request(OP_VALIDATE, ymd(2021, 5, 0), z, 16'd0);
        send_request(OP_VALIDATE, ymd(2021, 0, 10), z, 16'd0);
        // every base field at its maximum encoding
        send_request(OP_VALIDATE, ymd(16383, 15, 31), ymd(16383, 15, 31), 16'hFFFF);
        send_request(OP_VALIDATE, ymd(2023, 4, 31), z, 16'd0);
    endtask

    task automatic test_day_stepping();
        date_t z;
        z = ymd(0, 0, 0);
        send_request(OP_ADD, ymd(2021, 7, 31), z, 16'd1);
        send_request(OP_SUB, ymd(2021, 8, 1), z, 16'd1);         // lands on July 31
        send_request(OP_SUB, ymd(2020, 1, 1), z, 16'd1);         // back into last year
        send_request(OP_SUB, ymd(2000, 3, 1), z, 16'd1);         // onto Feb 29
        send_request(OP_ADD, ymd(1999, 6, 15), z, 16'd0);
        send_request(OP_ADD, ymd(0, 1, 1), z, 16'hFFFF);
        send_request(OP_ADD, ymd(9999, 12, 20), z, 16'd30);      // runs off the end
        send_request(OP_SUB, ymd(0, 1, 5), z, 16'd10);           // runs off the start
        send_request(OP_SUB, ymd(9999, 12, 31), z, 16'hFFFF);
        send_request(OP_ADD, ymd(2021, 2, 29), z, 16'd5);        // invalid base
    endtask

    task automatic test_distance();
        date_t b;
        b = ymd(2000, 1, 1);
        send_request(OP_DIST, b, b, 16'd0);
        send_request(OP_DIST, b, shift_date(b, -366), 16'd0);    // other before base
        send_request(OP_DIST, b, shift_date(b, 65535), 16'd0);   // exactly at the limit
        send_request(OP_DIST, b, shift_date(b, 65536), 16'd0);   // one past: saturates
        send_request(OP_DIST, b, ymd(2000, 13, 1), 16'd0);
        send_request(OP_DIST, b, ymd(16383, 15, 31), 16'd0);
    endtask

    task automatic send_random_item(input int idx);
        logic [1:0]  op;
        date_t       base;
        date_t       other;
        logic [15:0] count;
        bit          big;
        int          off;
        big = (idx % 100 == 50);   // a few long walks, the rest short
        op  = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 8) begin
            // raw noise: mostly invalid dates
            base  = ymd($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
            other = ymd($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
            count = 16'($urandom_range(0, 511));
        end else begin
            base = ymd(0, 1, 1);
            case ($urandom_range(0, 9))
                0:       base.year = 14'($urandom_range(0, 3));
                1:       base.year = 14'($urandom_range(9996, 9999));
                default: base.year = 14'($urandom_range(0, 9999));
            endcase
            base.month = 4'($urandom_range(1, 12));
            case ($urandom_range(0, 4))
                0:       base.day = 5'd1;
                1:       base.day = 5'(days_in_month(int'(base.month), int'(base.year)));
                default: base.day = 5'($urandom_range(1, days_in_month(int'(base.month),
                                                                       int'(base.year))));
            endcase
            if (big)
                count = 16'($urandom_range(0, 65535));
            else if ($urandom_range(0, 9) == 0)
                count = 16'($urandom_range(0, 2));
            else
                count = 16'($urandom_range(0, 400));
            off = big ? $urandom_range(0, 70000) : $urandom_range(0, 400);
            if ($urandom_range(0, 1))
                off = -off;
            other = shift_date(base, off);
            if ($urandom_range(0, 9) == 0)
                other = ymd($urandom_range(0, 16383), $urandom_range(0, 15),
                            $urandom_range(0, 31));
        end
        send_request(op, base, other, count);
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            no_gaps = (i >= n / 4) && (i < n / 4 + 60);
            // hold off once until the block has fully drained
            if (i == n / 2) begin
                release_bus();
                drain_results();
            end
            send_random_item(i);
        end
        no_gaps = 1'b0;
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        errors   = 0;
        no_gaps  = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_validation();
        test_day_stepping();
        test_distance();
        test_random_traffic(675);

        release_bus();
        drain_results();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("calendar_date_arithmetic_core test passed");
        else
            $display("calendar_date_arithmetic_core test failed");
        $finish;
    end
endmodule

`default_nettype wire
